// ===== sv/cfb_pkg.sv =====
// Shared types and constants for the command frame builder.
package cfb_pkg;

	// Framing bytes.
	localparam logic [7:0] HDR0   = 8'h3A;
	localparam logic [7:0] HDR1   = 8'h16;
	localparam logic [7:0] NOPAY0 = 8'h01;
	localparam logic [7:0] NOPAY1 = 8'h0B;
	localparam logic [7:0] TRL0   = 8'h0D;
	localparam logic [7:0] TRL1   = 8'h0A;

	// Default longest command, code byte included.
	localparam int MAX_CMD_LEN_DEF = 43;

	// Longest run of output bytes that one input beat can cause.
	localparam int MAX_RUN = 9;
	localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

	// One run of output bytes, first byte in entry 0.
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_CNT_W-1:0]    count;
		logic                    tail;
	} run_t;

endpackage

// ===== sv/cfb_frame_ctl.sv =====
// Input register, frame state and construction of the output run for one beat.
module cfb_frame_ctl #(
	parameter int MAX_CMD_LEN = cfb_pkg::MAX_CMD_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    cmd_byte,
	input  logic [5:0]    cmd_len,
	input  logic          run_free,
	output logic          run_load,
	output cfb_pkg::run_t run
);

	localparam int LenW = $clog2(MAX_CMD_LEN + 1);
	localparam logic [7:0] MaxLen = 8'(MAX_CMD_LEN);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [5:0]       len_s1;
	logic [LenW-1:0]  bytes_left_q;
	logic [15:0]      sum_q;

	logic             accept;
	logic             frame_start;
	logic             last_payload;
	logic [7:0]       len_one;
	logic [7:0]       len_sat;
	logic [7:0]       len_m1;
	logic [15:0]      sum_next;
	logic [LenW-1:0]  left_next;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !valid_s1 || run_free;
	assign run_load = valid_s1 && run_free;

	// Input register: one beat waits here while the output run drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (run_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= cmd_byte;
			len_s1  <= cmd_len;
		end
	end

	// Length clean-up: zero counts as one, too long saturates.
	assign frame_start  = (bytes_left_q == '0);
	assign len_one      = (len_s1 == 6'd0) ? 8'd1 : {2'b00, len_s1};
	assign len_sat      = (len_one > MaxLen) ? MaxLen : len_one;
	assign len_m1       = len_sat - 8'd1;
	assign last_payload = (bytes_left_q == LenW'(1));

	// Checksum after this beat's summed bytes.
	always_comb begin
		if (frame_start) begin
			if (len_sat > 8'd1) begin
				sum_next = 16'(cfb_pkg::HDR1) + 16'(byte_s1) + 16'(len_m1);
			end else begin
				sum_next = 16'(cfb_pkg::HDR1) + 16'(byte_s1)
					+ 16'(cfb_pkg::NOPAY0) + 16'(cfb_pkg::NOPAY1);
			end
		end else begin
			sum_next = sum_q + 16'(byte_s1);
		end
	end

	assign left_next = frame_start ? ((len_sat > 8'd1) ? LenW'(len_m1) : '0)
		: (bytes_left_q - LenW'(1));

	// Frame state moves on when the beat hands its run to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			sum_q        <= '0;
		end else if (run_load) begin
			bytes_left_q <= left_next;
			sum_q        <= (left_next == '0) ? 16'd0 : sum_next;
		end
	end

	// Build the run of output bytes for this beat.
	always_comb begin
		run = '0;
		if (frame_start) begin
			run.bytes[0] = cfb_pkg::HDR0;
			run.bytes[1] = cfb_pkg::HDR1;
			run.bytes[2] = byte_s1;
			if (len_sat > 8'd1) begin
				run.bytes[3] = len_m1;
				run.count    = cfb_pkg::RUN_CNT_W'(4);
			end else begin
				run.bytes[3] = cfb_pkg::NOPAY0;
				run.bytes[4] = cfb_pkg::NOPAY1;
				run.bytes[5] = sum_next[7:0];
				run.bytes[6] = sum_next[15:8];
				run.bytes[7] = cfb_pkg::TRL0;
				run.bytes[8] = cfb_pkg::TRL1;
				run.count    = cfb_pkg::RUN_CNT_W'(9);
				run.tail     = 1'b1;
			end
		end else begin
			run.bytes[0] = byte_s1;
			if (last_payload) begin
				run.bytes[1] = sum_next[7:0];
				run.bytes[2] = sum_next[15:8];
				run.bytes[3] = cfb_pkg::TRL0;
				run.bytes[4] = cfb_pkg::TRL1;
				run.count    = cfb_pkg::RUN_CNT_W'(5);
				run.tail     = 1'b1;
			end else begin
				run.count    = cfb_pkg::RUN_CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/cfb_run_buf.sv =====
// Result register that holds one run and shifts it out a beat at a time.
module cfb_run_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          run_load,
	input  cfb_pkg::run_t run,
	output logic          run_free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	output logic          m_tuser
);

	logic [cfb_pkg::MAX_RUN-1:0][7:0]  bytes_q;
	logic [cfb_pkg::RUN_CNT_W-1:0]     cnt_q;
	logic                              tail_q;
	logic                              out_beat;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = bytes_q[0];
	assign m_tlast  = (cnt_q == cfb_pkg::RUN_CNT_W'(1));
	assign m_tuser  = tail_q && m_tlast;
	assign out_beat = m_tvalid && m_tready;
	assign run_free = (cnt_q == '0) || (m_tlast && m_tready);

	// Remaining count and tail flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			tail_q <= 1'b0;
		end else if (run_load) begin
			cnt_q  <= run.count;
			tail_q <= run.tail;
		end else if (out_beat) begin
			cnt_q  <= cnt_q - cfb_pkg::RUN_CNT_W'(1);
		end
	end

	// Byte shift line: the byte at entry 0 is on the bus.
	always_ff @(posedge clk) begin
		if (run_load) begin
			bytes_q <= run.bytes;
		end else if (out_beat) begin
			bytes_q <= {8'h00, bytes_q[cfb_pkg::MAX_RUN-1:1]};
		end
	end

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end flagged on a beat that does not close its run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cfb_pkg::RUN_CNT_W'(cfb_pkg::MAX_RUN))
		else $error("run count beyond the longest run");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |-> (cnt_q == '0) || (m_tlast && m_tready))
		else $error("new run loaded over bytes not yet sent");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(cnt_q) && $stable(m_tdata))
		else $error("output run changed while stalled");

endmodule

// ===== sv/command_frame_builder.sv =====
// Top level of the command frame builder.
// Takes one command byte per beat and emits the framed stream 0x3A 0x16, the
// code, then either the length byte (length minus one) and the payload or the
// pair 0x01 0x0B, then the 16-bit additive checksum low byte first and the
// trailer 0x0D 0x0A. cmd_len is read on a frame's first byte only; zero counts
// as one and values above MAX_CMD_LEN saturate. Each input beat waits in the
// input register and then goes out as its run of output bytes: 1 for a middle
// payload byte, 4 for a frame start with payload, 5 for the last payload byte,
// 9 for a frame with no payload. The output port at one byte per cycle while
// m_tready is high sets the throughput; payload bytes then flow at one per
// cycle, and one input beat is taken while a run still waits.
module command_frame_builder #(
	parameter int MAX_CMD_LEN = cfb_pkg::MAX_CMD_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] cmd_byte, [13:8] cmd_len, [15:14] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser    // [0] frame_end
);

	cfb_pkg::run_t run;
	logic          run_free;
	logic          run_load;

	// Frame state and run construction.
	cfb_frame_ctl #(
		.MAX_CMD_LEN(MAX_CMD_LEN)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd_byte (s_tdata[7:0]),
		.cmd_len  (s_tdata[13:8]),
		.run_free (run_free),
		.run_load (run_load),
		.run      (run)
	);

	// Output run register.
	cfb_run_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_load (run_load),
		.run      (run),
		.run_free (run_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
